FILE: rtl/stg_pkg.sv
// shared constants, types and helper functions of the skyrmion texture generator
package stg_pkg;

    localparam int GRID_SIDE    = 1024;
    localparam int ANGLE_STAGES = 16;
    localparam int TAB_LEN      = 24;
    localparam int CORDIC_N     = (ANGLE_STAGES < TAB_LEN) ? ANGLE_STAGES : TAB_LEN;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 17;
    localparam int SIDE_DLY     = SQRT_STEPS + 1;
    // rotation result waits for the magnitude path
    localparam int CS_DLY       = 52 - 2 * CORDIC_N;
    localparam int PIPE_LEN     = 58;

    localparam logic [12:0] CELL_MAX = 13'(GRID_SIDE - 1);

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [33:0] QUARTER_S    = 34'sh40000000;
    localparam logic signed [33:0] HALF_S       = 34'sh80000000;
    localparam logic [31:0]        QUARTER_U    = 32'h40000000;
    localparam logic [31:0]        HALF_U       = 32'h80000000;

    localparam logic [3:0] REG_CELL_DX   = 4'd0;
    localparam logic [3:0] REG_CELL_DY   = 4'd1;
    localparam logic [3:0] REG_ORIGIN_X  = 4'd2;
    localparam logic [3:0] REG_ORIGIN_Y  = 4'd3;
    localparam logic [3:0] REG_RADIUS    = 4'd4;
    localparam logic [3:0] REG_WALL_KIND = 4'd5;
    localparam logic [3:0] REG_WINDING   = 4'd6;
    localparam logic [3:0] REG_CORE_POL  = 4'd7;

    typedef struct packed {
        logic [55:0] den;
        logic [55:0] num;
        logic        neg;
        logic        zero;
    } mag_side_t;

    typedef struct packed {
        logic [39:0] n;
        logic [39:0] d;
    } norm_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } mag_flag_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10680862;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // halve numerator and denominator together until the denominator is below 2^40
    function automatic norm_t norm_pair(input logic [63:0] n_in, input logic [63:0] d_in);
        logic [63:0] n;
        logic [63:0] d;
        norm_t       r;
        n = n_in;
        d = d_in;
        for (int j = 4; j >= 0; j--) begin
            if (d >= (64'd1 << (39 + (1 << j)))) begin
                n = n >> (1 << j);
                d = d >> (1 << j);
            end
        end
        r.n = n[39:0];
        r.d = d[39:0];
        return r;
    endfunction

    function automatic logic [15:0] sat_q15(input logic signed [51:0] v);
        logic [15:0] r;
        if (v > 52'sd32767) begin
            r = 16'h7fff;
        end else if (v < -52'sd32767) begin
            r = 16'h8001;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/stg_vec_cell.sv
// one vectoring cordic cell: rotates (x,y) towards the x axis and sums the angle
module stg_vec_cell import stg_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [4:0]         stage,
    input  logic signed [53:0] x_in,
    input  logic signed [53:0] y_in,
    input  logic [31:0]        z_in,
    output logic signed [53:0] x_out,
    output logic signed [53:0] y_out,
    output logic [31:0]        z_out
);

    logic signed [53:0] x_reg;
    logic signed [53:0] y_reg;
    logic [31:0]        z_reg;
    logic signed [53:0] x_sh;
    logic signed [53:0] y_sh;
    logic [31:0]        step_ang;

    assign x_sh     = x_in >>> stage;
    assign y_sh     = y_in >>> stage;
    assign step_ang = atan_entry(stage);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!y_in[53]) begin
                x_reg <= x_in + y_sh;
                y_reg <= y_in - x_sh;
                z_reg <= z_in + step_ang;
            end else begin
                x_reg <= x_in - y_sh;
                y_reg <= y_in + x_sh;
                z_reg <= z_in - step_ang;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

FILE: rtl/stg_rot_cell.sv
// one rotation cordic cell: turns (x,y) by the next table angle towards residual zero
module stg_rot_cell import stg_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [4:0]         stage,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [33:0] x_out,
    output logic signed [33:0] y_out,
    output logic signed [33:0] z_out
);

    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [33:0] step_ang;

    assign x_sh     = x_in >>> stage;
    assign y_sh     = y_in >>> stage;
    assign step_ang = $signed({2'b00, atan_entry(stage)});

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!z_in[33]) begin
                x_reg <= x_in - y_sh;
                y_reg <= y_in + x_sh;
                z_reg <= z_in - step_ang;
            end else begin
                x_reg <= x_in + y_sh;
                y_reg <= y_in - x_sh;
                z_reg <= z_in + step_ang;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

FILE: rtl/stg_sqrt_cell.sv
// one digit of the integer square root: takes two radicand bits, yields one root bit
module stg_sqrt_cell import stg_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [33:0] rem_in,
    input  logic [31:0] root_in,
    input  logic [63:0] rad_in,
    output logic [33:0] rem_out,
    output logic [31:0] root_out,
    output logic [63:0] rad_out
);

    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] rad_reg;
    logic [35:0] part;
    logic [35:0] trial;

    assign part  = {rem_in, rad_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge aclk) begin
        if (en) begin
            if (part >= trial) begin
                rem_reg  <= 34'(part - trial);
                root_reg <= {root_in[30:0], 1'b1};
            end else begin
                rem_reg  <= part[33:0];
                root_reg <= {root_in[30:0], 1'b0};
            end
            rad_reg <= {rad_in[61:0], 2'b00};
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

FILE: rtl/stg_div_cell.sv
// one restoring division step: one quotient bit per cell
module stg_div_cell import stg_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [39:0] rem_in,
    input  logic [39:0] den_in,
    input  logic [16:0] low_in,
    input  logic [16:0] quo_in,
    output logic [39:0] rem_out,
    output logic [39:0] den_out,
    output logic [16:0] low_out,
    output logic [16:0] quo_out
);

    logic [39:0] rem_reg;
    logic [39:0] den_reg;
    logic [16:0] low_reg;
    logic [16:0] quo_reg;
    logic [40:0] part;

    assign part = {rem_in, low_in[16]};

    always_ff @(posedge aclk) begin
        if (en) begin
            if (part >= {1'b0, den_in}) begin
                rem_reg <= 40'(part - {1'b0, den_in});
                quo_reg <= {quo_in[15:0], 1'b1};
            end else begin
                rem_reg <= part[39:0];
                quo_reg <= {quo_in[15:0], 1'b0};
            end
            den_reg <= den_in;
            low_reg <= {low_in[15:0], 1'b0};
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign low_out = low_reg;
    assign quo_out = quo_reg;

endmodule

FILE: rtl/skyrmion_texture_generator_top.sv
// Skyrmion texture generator: takes one cell index pair per beat and returns the Q1.15 unit
// magnetization of that cell. It accepts one cell every clock unless the output skid beat is
// full, and returns results in order; the depth is set by the 32-cell square root chain and the
// 17-cell divide chain that form the polar profile, with the cordic angle chains running
// alongside. A two-entry output stage keeps input flowing while a result waits.
// Configuration writes are taken at any time but must only happen while the block is empty.
module skyrmion_texture_generator_top import stg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cell_x[9:0], cell_y[19:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // mag_x[15:0], mag_y[31:16], mag_z[47:32]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    // configuration registers
    logic [15:0] cell_dx_reg;
    logic [15:0] cell_dy_reg;
    logic [25:0] origin_x_reg;
    logic [25:0] origin_y_reg;
    logic [23:0] radius_reg;
    logic        wall_kind_reg;
    logic [4:0]  winding_reg;
    logic [1:0]  core_pol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_dx_reg   <= 16'd16;
            cell_dy_reg   <= 16'd16;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            radius_reg    <= 24'd256;
            wall_kind_reg <= 1'b0;
            winding_reg   <= 5'd1;
            core_pol_reg  <= 2'd1;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_CELL_DX:   cell_dx_reg   <= cfg_data[15:0];
                REG_CELL_DY:   cell_dy_reg   <= cfg_data[15:0];
                REG_ORIGIN_X:  origin_x_reg  <= cfg_data[25:0];
                REG_ORIGIN_Y:  origin_y_reg  <= cfg_data[25:0];
                REG_RADIUS:    radius_reg    <= cfg_data[23:0];
                REG_WALL_KIND: wall_kind_reg <= cfg_data[0];
                REG_WINDING:   winding_reg   <= cfg_data[4:0];
                REG_CORE_POL:  core_pol_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic                adv;
    logic                push;
    logic [PIPE_LEN-1:0] vld_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;
    logic [47:0]         out_data_reg;
    logic [47:0]         skid_data_reg;
    logic [47:0]         res_data;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign push     = adv && vld_reg[PIPE_LEN-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_tvalid};
        end
    end

    // input stage with index clamp
    logic [9:0]  ix_reg;
    logic [9:0]  iy_reg;
    logic [9:0]  ix_cl;
    logic [9:0]  iy_cl;

    assign ix_cl = (13'(s_tdata[9:0]) > CELL_MAX) ? CELL_MAX[9:0] : s_tdata[9:0];
    assign iy_cl = (13'(s_tdata[19:10]) > CELL_MAX) ? CELL_MAX[9:0] : s_tdata[19:10];

    // position
    logic [25:0]        prod_x;
    logic [25:0]        prod_y;
    logic signed [27:0] x_reg;
    logic signed [27:0] y_reg;

    assign prod_x = 26'(ix_reg) * 26'(cell_dx_reg);
    assign prod_y = 26'(iy_reg) * 26'(cell_dy_reg);

    // squares and radial terms
    logic signed [55:0] sqx;
    logic signed [55:0] sqy;
    logic [47:0]        r2_w;
    logic [53:0]        x2_reg;
    logic [53:0]        y2_reg;
    logic [47:0]        r2_reg;
    logic [54:0]        s_reg;
    logic [63:0]        rad4_reg;
    mag_side_t          side4_reg;

    assign sqx  = x_reg * x_reg;
    assign sqy  = y_reg * y_reg;
    assign r2_w = radius_reg * radius_reg;

    // vectoring front end
    logic signed [53:0] vx_init;
    logic signed [53:0] vy_init;
    logic signed [53:0] vx0_reg;
    logic signed [53:0] vy0_reg;
    logic [31:0]        vz0_reg;

    assign vx_init = $signed({{2{x_reg[27]}}, x_reg, 24'd0});
    assign vy_init = $signed({{2{y_reg[27]}}, y_reg, 24'd0});

    always_ff @(posedge aclk) begin
        if (adv) begin
            ix_reg <= ix_cl;
            iy_reg <= iy_cl;
            x_reg  <= $signed({2'b00, prod_x}) + $signed({{2{origin_x_reg[25]}}, origin_x_reg});
            y_reg  <= $signed({2'b00, prod_y}) + $signed({{2{origin_y_reg[25]}}, origin_y_reg});
            x2_reg <= sqx[53:0];
            y2_reg <= sqy[53:0];
            s_reg  <= 55'(x2_reg) + 55'(y2_reg);
            rad4_reg        <= {1'b0, s_reg, 8'd0};
            side4_reg.den   <= 56'(s_reg) + 56'(r2_reg);
            side4_reg.num   <= (s_reg >= 55'(r2_reg)) ? 56'(s_reg - 55'(r2_reg))
                                                      : 56'(55'(r2_reg) - s_reg);
            side4_reg.neg   <= s_reg < 55'(r2_reg);
            side4_reg.zero  <= s_reg == '0;
            if (x_reg < 0) begin
                vx0_reg <= -vx_init;
                vy0_reg <= -vy_init;
                vz0_reg <= HALF_U;
            end else begin
                vx0_reg <= vx_init;
                vy0_reg <= vy_init;
                vz0_reg <= '0;
            end
        end
    end

    // depends on configuration only
    always_ff @(posedge aclk) begin
        r2_reg <= r2_w;
    end

    // vectoring cordic chain
    logic signed [53:0] vx [0:CORDIC_N];
    logic signed [53:0] vy [0:CORDIC_N];
    logic [31:0]        vz [0:CORDIC_N];

    assign vx[0] = vx0_reg;
    assign vy[0] = vy0_reg;
    assign vz[0] = vz0_reg;

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_vec
        stg_vec_cell u_cell (
            .aclk  (aclk),
            .en    (adv),
            .stage (5'(i)),
            .x_in  (vx[i]),
            .y_in  (vy[i]),
            .z_in  (vz[i]),
            .x_out (vx[i+1]),
            .y_out (vy[i+1]),
            .z_out (vz[i+1])
        );
    end

    // winding, wall turn and fold for the rotation chain
    logic [31:0]        wind32;
    logic [31:0]        ang_m;
    logic [31:0]        ang_reg;
    logic signed [33:0] z_ext;
    logic signed [33:0] rx0_reg;
    logic signed [33:0] rz0_reg;

    assign wind32 = {{27{winding_reg[4]}}, winding_reg};
    assign ang_m  = vz[CORDIC_N] * wind32;
    assign z_ext  = $signed({{2{ang_reg[31]}}, ang_reg});

    always_ff @(posedge aclk) begin
        if (adv) begin
            ang_reg <= ang_m + (wall_kind_reg ? QUARTER_U : 32'd0);
            if (z_ext > QUARTER_S) begin
                rx0_reg <= -CORDIC_START;
                rz0_reg <= z_ext - HALF_S;
            end else if (z_ext < -QUARTER_S) begin
                rx0_reg <= -CORDIC_START;
                rz0_reg <= z_ext + HALF_S;
            end else begin
                rx0_reg <= CORDIC_START;
                rz0_reg <= z_ext;
            end
        end
    end

    // rotation cordic chain
    logic signed [33:0] rx [0:CORDIC_N];
    logic signed [33:0] ry [0:CORDIC_N];
    logic signed [33:0] rz [0:CORDIC_N];

    assign rx[0] = rx0_reg;
    assign ry[0] = '0;
    assign rz[0] = rz0_reg;

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
        stg_rot_cell u_cell (
            .aclk  (aclk),
            .en    (adv),
            .stage (5'(i)),
            .x_in  (rx[i]),
            .y_in  (ry[i]),
            .z_in  (rz[i]),
            .x_out (rx[i+1]),
            .y_out (ry[i+1]),
            .z_out (rz[i+1])
        );
    end

    // cos and sin wait for the magnitude path
    logic signed [33:0] cn_dly_reg [0:CS_DLY-1];
    logic signed [33:0] sn_dly_reg [0:CS_DLY-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            cn_dly_reg[0] <= rx[CORDIC_N];
            sn_dly_reg[0] <= ry[CORDIC_N];
            for (int k = 1; k < CS_DLY; k++) begin
                cn_dly_reg[k] <= cn_dly_reg[k-1];
                sn_dly_reg[k] <= sn_dly_reg[k-1];
            end
        end
    end

    // square root chain on 256*rho^2
    logic [33:0] sq_rem  [0:SQRT_STEPS];
    logic [31:0] sq_root [0:SQRT_STEPS];
    logic [63:0] sq_rad  [0:SQRT_STEPS];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = rad4_reg;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        stg_sqrt_cell u_cell (
            .aclk     (aclk),
            .en       (adv),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .rad_in   (sq_rad[i]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1]),
            .rad_out  (sq_rad[i+1])
        );
    end

    mag_side_t side_reg [0:SIDE_DLY-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side4_reg;
            for (int k = 1; k < SIDE_DLY; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // sine numerator, then normalise both ratios
    logic [56:0] nsin_w;
    logic [56:0] nsin_reg;
    mag_side_t   side_last;
    norm_t       ns;
    norm_t       nc;
    logic [55:0] nfull_s;
    logic [55:0] nfull_c;
    logic [39:0] ds_rem_reg;
    logic [39:0] ds_den_reg;
    logic [16:0] ds_low_reg;
    logic [39:0] dc_rem_reg;
    logic [39:0] dc_den_reg;
    logic [16:0] dc_low_reg;
    mag_flag_t   flag0_reg;

    assign nsin_w    = 57'({radius_reg, 1'b0}) * 57'(sq_root[SQRT_STEPS]);
    assign side_last = side_reg[SIDE_DLY-1];
    assign ns        = norm_pair(64'(nsin_reg), {4'd0, side_last.den, 4'd0});
    assign nc        = norm_pair(64'(side_last.num), 64'(side_last.den));
    // rounding: n*32768 + d/2
    assign nfull_s   = 56'({ns.n, 15'd0}) + 56'(ns.d[39:1]);
    assign nfull_c   = 56'({nc.n, 15'd0}) + 56'(nc.d[39:1]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            nsin_reg       <= nsin_w;
            ds_rem_reg     <= {1'b0, nfull_s[55:17]};
            ds_den_reg     <= ns.d;
            ds_low_reg     <= nfull_s[16:0];
            dc_rem_reg     <= {1'b0, nfull_c[55:17]};
            dc_den_reg     <= nc.d;
            dc_low_reg     <= nfull_c[16:0];
            flag0_reg.neg  <= side_last.neg;
            flag0_reg.zero <= side_last.zero;
        end
    end

    // divide chains, sine and cosine lanes side by side
    logic [39:0] s_rem [0:DIV_STEPS];
    logic [39:0] s_den [0:DIV_STEPS];
    logic [16:0] s_low [0:DIV_STEPS];
    logic [16:0] s_quo [0:DIV_STEPS];
    logic [39:0] c_rem [0:DIV_STEPS];
    logic [39:0] c_den [0:DIV_STEPS];
    logic [16:0] c_low [0:DIV_STEPS];
    logic [16:0] c_quo [0:DIV_STEPS];

    assign s_rem[0] = ds_rem_reg;
    assign s_den[0] = ds_den_reg;
    assign s_low[0] = ds_low_reg;
    assign s_quo[0] = '0;
    assign c_rem[0] = dc_rem_reg;
    assign c_den[0] = dc_den_reg;
    assign c_low[0] = dc_low_reg;
    assign c_quo[0] = '0;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        stg_div_cell u_sin (
            .aclk    (aclk),
            .en      (adv),
            .rem_in  (s_rem[i]),
            .den_in  (s_den[i]),
            .low_in  (s_low[i]),
            .quo_in  (s_quo[i]),
            .rem_out (s_rem[i+1]),
            .den_out (s_den[i+1]),
            .low_out (s_low[i+1]),
            .quo_out (s_quo[i+1])
        );
        stg_div_cell u_cos (
            .aclk    (aclk),
            .en      (adv),
            .rem_in  (c_rem[i]),
            .den_in  (c_den[i]),
            .low_in  (c_low[i]),
            .quo_in  (c_quo[i]),
            .rem_out (c_rem[i+1]),
            .den_out (c_den[i+1]),
            .low_out (c_low[i+1]),
            .quo_out (c_quo[i+1])
        );
    end

    mag_flag_t flag_reg [0:DIV_STEPS-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            flag_reg[0] <= flag0_reg;
            for (int k = 1; k < DIV_STEPS; k++) begin
                flag_reg[k] <= flag_reg[k-1];
            end
        end
    end

    // signed profile, products and output rounding
    mag_flag_t          flag_last;
    logic signed [17:0] sinq_reg;
    logic signed [17:0] cosq_reg;
    logic signed [17:0] qc_s;
    logic signed [51:0] px_reg;
    logic signed [51:0] py_reg;
    logic signed [19:0] mz_reg;
    logic signed [19:0] mz_w;
    logic signed [51:0] rnd_x;
    logic signed [51:0] rnd_y;

    assign flag_last = flag_reg[DIV_STEPS-1];
    assign qc_s      = $signed({1'b0, c_quo[DIV_STEPS]});
    assign mz_w      = -($signed(core_pol_reg) * cosq_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (flag_last.zero) begin
                sinq_reg <= '0;
                cosq_reg <= -18'sd32768;
            end else begin
                sinq_reg <= $signed({1'b0, s_quo[DIV_STEPS]});
                cosq_reg <= flag_last.neg ? -qc_s : qc_s;
            end
            px_reg <= sinq_reg * cn_dly_reg[CS_DLY-1];
            py_reg <= sinq_reg * sn_dly_reg[CS_DLY-1];
            mz_reg <= mz_w;
        end
    end

    assign rnd_x    = (px_reg + 52'sd536870912) >>> 30;
    assign rnd_y    = (py_reg + 52'sd536870912) >>> 30;
    assign res_data = {sat_q15(52'(mz_reg)), sat_q15(rnd_y), sat_q15(rnd_x)};

    // output register with skid beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end else if (push) begin
            skid_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held without an output beat");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && push) |=> skid_valid_reg)
        else $error("result lost while output stalled");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid beat not moved to output");

endmodule
